/* src/i2c_register_write_master_top_assert.svh */
// Assertion macros used by the checker file.
`ifndef I2C_REGISTER_WRITE_MASTER_TOP_ASSERT_SVH
`define I2C_REGISTER_WRITE_MASTER_TOP_ASSERT_SVH

// Checked property, off while reset is asserted.
`define I2C_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked property that also holds through reset.
`define I2C_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/i2c_rw_pkg.sv */
// ----------------------------------------------------------------------------
// i2c_rw_pkg
// Shared types and constants for the bit-banged I2C register write master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_rw_pkg;

    // Width of the phase hold counter
    localparam int DelayW = 16;
    // Width of the configuration data bus (widest register)
    localparam int CfgW   = 16;

    localparam logic [7:0] DevAddrReset   = 8'd192;
    localparam logic [15:0] DelayReset    = 16'd100;

    typedef enum logic [1:0] {
        CFG_DEV_ADDR    = 2'd0,
        CFG_DATA_DELAY  = 2'd1,
        CFG_CLOCK_DELAY = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic       command;
        logic [7:0] register_address;
        logic [7:0] write_value;
    } cmd_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic busy_res;
        logic request_rejected;
        logic transfer_done;
    } rsp_t;

    // Beat class decided by the front end
    typedef enum logic {
        TICK_PLAIN   = 1'b0,
        TICK_REQUEST = 1'b1
    } tick_kind_t;

    typedef struct packed {
        tick_kind_t kind;
        logic [7:0] register_address;
        logic [7:0] write_value;
    } tick_t;

    typedef struct packed {
        logic [7:0]        dev_addr;
        logic [CfgW-1:0]   data_delay;
        logic [CfgW-1:0]   clock_delay;
    } cfg_t;

endpackage

`default_nettype wire

/* src/i2c_rw_front.sv */
// ----------------------------------------------------------------------------
// i2c_rw_front
// Accepts command beats, tags them as plain ticks or write requests and
// holds them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rw_front
    import i2c_rw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    output logic       cmd_ready,
    input  wire cmd_t  cmd_data,
    output logic       tick_valid,
    input  wire logic  tick_ready,
    output tick_t      tick
);

    tick_t       q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    tick_t       entry;

    assign cmd_ready  = (count_reg != 2'd2);
    assign tick_valid = (count_reg != 2'd0);
    assign tick       = q_reg[rd_ptr_reg];
    assign push       = cmd_valid && cmd_ready;
    assign pop        = tick_valid && tick_ready;

    always_comb
    begin
        entry.kind             = cmd_data.command ? TICK_REQUEST : TICK_PLAIN;
        entry.register_address = cmd_data.register_address;
        entry.write_value      = cmd_data.write_value;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

/* src/i2c_rw_back.sv */
// ----------------------------------------------------------------------------
// i2c_rw_back
// Bus sequencer: advances one tick per queued beat and registers the line
// levels and status into the response stage.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_rw_back
    import i2c_rw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  tick_valid,
    output logic       tick_ready,
    input  wire tick_t tick,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output rsp_t       rsp_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_BIT,
        PH_ACK,
        PH_STOP
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [1:0]          step_reg, step_next;
    logic [2:0]          bit_reg, bit_next;
    logic [1:0]          byte_reg, byte_next;
    logic [7:0]          shift_reg, shift_next;
    logic [7:0]          hreg_reg, hreg_next;
    logic [7:0]          hval_reg, hval_next;
    logic [DelayW-1:0]   wait_reg, wait_next;
    logic                sda_reg, sda_next;
    logic                scl_reg, scl_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;
    logic                fire;
    logic                enter;
    logic                use_clk;
    logic                rejected;
    logic                done;
    logic [DelayW-1:0]   delay;

    function automatic logic [7:0] byte_for(input logic [1:0] idx,
                                            input logic [7:0] dev,
                                            input logic [7:0] r,
                                            input logic [7:0] v);
        logic [7:0] b;
        begin
            if (idx == 2'd0)
                b = dev;
            else if (idx == 2'd1)
                b = r;
            else
                b = v;
            return b;
        end
    endfunction

    assign tick_ready = !rsp_valid_reg || rsp_ready;
    assign fire       = tick_valid && tick_ready;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_reg;

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        hreg_next  = hreg_reg;
        hval_next  = hval_reg;
        wait_next  = wait_reg;
        sda_next   = sda_reg;
        scl_next   = scl_reg;
        rejected   = 1'b0;
        done       = 1'b0;
        enter      = 1'b0;
        use_clk    = 1'b0;
        delay      = '0;

        if (phase_reg == PH_IDLE)
        begin
            if (tick.kind == TICK_REQUEST)
            begin
                hreg_next  = tick.register_address;
                hval_next  = tick.write_value;
                phase_next = PH_START;
                step_next  = 2'd0;
                bit_next   = 3'd0;
                byte_next  = 2'd0;
                enter      = 1'b1;
            end
        end
        else
        begin
            rejected = (tick.kind == TICK_REQUEST);
            if (wait_reg != '0)
            begin
                wait_next = wait_reg - DelayW'(1);
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (step_reg < 2'd3)
                        begin
                            step_next = step_reg + 2'd1;
                        end
                        else
                        begin
                            phase_next = PH_BIT;
                            step_next  = 2'd0;
                            byte_next  = 2'd0;
                            bit_next   = 3'd0;
                            shift_next = cfg.dev_addr;
                        end
                    end
                    PH_BIT:
                    begin
                        if (step_reg < 2'd2)
                        begin
                            step_next = step_reg + 2'd1;
                        end
                        else
                        begin
                            shift_next = {shift_reg[6:0], 1'b0};
                            step_next  = 2'd0;
                            if (bit_reg == 3'd7)
                            begin
                                bit_next   = 3'd0;
                                phase_next = PH_ACK;
                            end
                            else
                            begin
                                bit_next = bit_reg + 3'd1;
                            end
                        end
                    end
                    PH_ACK:
                    begin
                        if (step_reg < 2'd2)
                        begin
                            step_next = step_reg + 2'd1;
                        end
                        else
                        begin
                            step_next = 2'd0;
                            if (byte_reg >= 2'd2)
                            begin
                                byte_next  = 2'd0;
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                byte_next  = byte_reg + 2'd1;
                                bit_next   = 3'd0;
                                shift_next = byte_for(byte_next, cfg.dev_addr,
                                                      hreg_reg, hval_reg);
                                phase_next = PH_BIT;
                            end
                        end
                    end
                    PH_STOP:
                    begin
                        if (step_reg < 2'd2)
                        begin
                            step_next = step_reg + 2'd1;
                        end
                        else
                        begin
                            step_next  = 2'd0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        step_next  = 2'd0;
                    end
                endcase
                enter = (phase_next != PH_IDLE);
            end
        end

        // Line change and hold time of the step just entered
        if (enter)
        begin
            use_clk = (step_next == 2'd1);
            unique case (phase_next)
                PH_START:
                begin
                    unique case (step_next)
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                PH_BIT:
                begin
                    if (step_next == 2'd0)
                        sda_next = shift_next[7];
                    else
                        scl_next = (step_next == 2'd1);
                end
                PH_ACK:
                begin
                    if (step_next == 2'd0)
                        sda_next = 1'b0;
                    else
                        scl_next = (step_next == 2'd1);
                end
                PH_STOP:
                begin
                    if (step_next == 2'd0)
                        sda_next = 1'b0;
                    else if (step_next == 2'd1)
                        scl_next = 1'b1;
                    else
                        sda_next = 1'b1;
                end
                default:
                begin
                    use_clk = 1'b0;
                end
            endcase
            delay     = use_clk ? DelayW'(cfg.clock_delay) : DelayW'(cfg.data_delay);
            wait_next = (delay == '0) ? '0 : delay - DelayW'(1);
        end

        rsp_next.scl_level        = scl_next;
        rsp_next.sda_level        = sda_next;
        rsp_next.busy_res         = (phase_next != PH_IDLE);
        rsp_next.request_rejected = rejected;
        rsp_next.transfer_done    = done;

        if (fire)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= 2'd0;
            bit_reg       <= 3'd0;
            byte_reg      <= 2'd0;
            shift_reg     <= 8'd0;
            hreg_reg      <= 8'd0;
            hval_reg      <= 8'd0;
            wait_reg      <= '0;
            sda_reg       <= 1'b1;
            scl_reg       <= 1'b1;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                step_reg  <= step_next;
                bit_reg   <= bit_next;
                byte_reg  <= byte_next;
                shift_reg <= shift_next;
                hreg_reg  <= hreg_next;
                hval_reg  <= hval_next;
                wait_reg  <= wait_next;
                sda_reg   <= sda_next;
                scl_reg   <= scl_next;
                rsp_reg   <= rsp_next;
            end
        end
    end

endmodule

`default_nettype wire

/* src/i2c_register_write_master_top.sv */
// ----------------------------------------------------------------------------
// i2c_register_write_master_top
// Write-only I2C master: one command beat is one bus timing tick.
// ----------------------------------------------------------------------------
// Usage notes:
//   cmd channel: one beat per timing tick. command=1 asks for a register
//     write (register_address, write_value); it is taken only when idle,
//     otherwise the response flags request_rejected.
//   rsp channel: exactly one beat per command beat, in order, carrying the
//     SCL/SDA levels after that tick plus busy / rejected / done flags.
//   Path: a taken command beat passes through the queue register, then
//     the response register, from which its response is offered.
//   Throughput: one beat per cycle sustained; the sequencer retires one
//     queued tick per cycle, limited only by the response register.
//   Stalls: if rsp_ready is low the response register holds, the
//     sequencer pauses and the two-entry queue soaks up two more beats
//     before cmd_ready drops.
//   Reset: both lines high, sequencer idle, queue empty, registers at their
//     defaults (address 0xC0, both delays 100 ticks).
//   Config: write-only port, used while idle; index 3 is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_register_write_master_top
    import i2c_rw_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire cmd_t            cmd_data,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output rsp_t                 rsp_data,
    input  wire logic            cfg_write_en,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [CfgW-1:0] cfg_data
);

    cfg_t   cfg_reg;
    logic   tick_valid;
    logic   tick_ready;
    tick_t  tick;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dev_addr    <= DevAddrReset;
            cfg_reg.data_delay  <= DelayReset;
            cfg_reg.clock_delay <= DelayReset;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEV_ADDR:    cfg_reg.dev_addr    <= cfg_data[7:0];
                CFG_DATA_DELAY:  cfg_reg.data_delay  <= cfg_data;
                CFG_CLOCK_DELAY: cfg_reg.clock_delay <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Front end: accept and tag beats, two-entry queue
    i2c_rw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_data   (cmd_data),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick)
    );

    // Back end: bus sequencer and response register
    i2c_rw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .tick       (tick),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data)
    );

endmodule

`default_nettype wire

/* src/i2c_rw_checker.sv */
// ----------------------------------------------------------------------------
// i2c_rw_checker
// Port-level checks for the I2C register write master, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_register_write_master_top_assert.svh"

module i2c_rw_checker
    import i2c_rw_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            cmd_ready,
    input wire logic            rsp_valid,
    input wire logic            rsp_ready,
    input wire rsp_t            rsp_data
);

    `I2C_ASSERT_ALWAYS(a_no_rsp_in_reset, clk, !rst_n |-> !rsp_valid, "response during reset")
    `I2C_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled response changed")
    `I2C_ASSERT(a_idle_lines_high, clk, rst_n, rsp_valid && !rsp_data.busy_res |-> rsp_data.scl_level && rsp_data.sda_level, "bus not released while idle")
    `I2C_ASSERT(a_done_is_stop, clk, rst_n, rsp_valid && rsp_data.transfer_done |-> !rsp_data.busy_res, "done while still busy")
    // input only backs up behind a held response beat
    `I2C_ASSERT(a_full_means_stalled, clk, rst_n, !cmd_ready |-> rsp_valid, "input stalled with no response pending")

endmodule

bind i2c_register_write_master_top i2c_rw_checker u_i2c_rw_checker (.*);

`default_nettype wire
